// ===== rtl/core/ksdh_pkg.sv =====
package ksdh_pkg;

    localparam int IdW   = 24;
    localparam int DistW = 32;

    typedef enum logic [1:0] {
        KIND_OFFER = 2'd0,
        KIND_DRAIN = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [DistW-1:0] distance;
    } entry_t;

endpackage

// ===== rtl/core/k_smallest_distance_heap.sv =====
// Channel | Dir | tdata (low bit first)                   | tuser (low bit first) | tlast
// s_      | in  | kind[1:0] item_id[25:2] distance[57:26] | -                     | -
// m_      | out | out_id[23:0] out_distance[55:24]        | found, empty_res      | last
// Offer below capacity: the entry climbs one level per parent read and compare.
// Offer at capacity: the root is read and compared; on a replace, the entry sifts down,
// reading both children and writing one slot per level descended.
// Drain of n entries: one sift-down per slot for n-1 slots, then one result per entry;
// check: every entry is read and compared, then one result is sent; output stalls hold results.
// Reset clears the entry count and the output valid; entries are undefined until written.
// s_tready is high only while idle; a result held in the output register does not block it.
module k_smallest_distance_heap #(
    parameter int HEAP_CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind[1:0], item_id[25:2], distance[57:26], zero[63:58]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_id[23:0], out_distance[55:24], zero[63:56]
    output logic [63:0] m_tdata,
    // found[0], empty_res[1]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    import ksdh_pkg::*;

    localparam int AW = (HEAP_CAPACITY > 1) ? $clog2(HEAP_CAPACITY) : 1;
    localparam int CW = $clog2(HEAP_CAPACITY + 1);
    localparam int PW = AW + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_UP_RD, S_UP_CMP, S_ROOT_RD, S_ROOT_CMP,
        S_DN_L, S_DN_R, S_DN_C, S_DN_W,
        S_SORT_RD, S_SORT_SWAP, S_SORT_LD,
        S_OUT_RD, S_OUT, S_CHK_RD, S_CHK, S_RES
    } state_t;

    entry_t mem [HEAP_CAPACITY];
    entry_t rd_reg;
    logic [AW-1:0] rd_addr;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] lim_reg;   // heap size for sift-down
    logic [CW-1:0] idx_reg;   // sort / scan / output index; zero during an offer
    logic [PW-1:0] pos_reg;   // hole position while sifting
    logic [PW-1:0] big_reg;
    entry_t cur_reg;          // entry being sifted
    entry_t big_e_reg;
    logic [IdW-1:0] key_reg;
    logic hit_reg;
    logic empty_reg;

    logic [PW-1:0] lch, rch, par;
    assign lch = {pos_reg[PW-2:0], 1'b1};
    assign rch = lch + PW'(1);
    assign par = (pos_reg - PW'(1)) >> 1;

    logic up_move;
    logic right_wins;
    logic at_last;
    logic out_load;
    kind_t s_kind;
    assign up_move    = rd_reg.distance < cur_reg.distance;
    assign right_wins = rd_reg.distance > big_e_reg.distance;
    assign at_last    = (idx_reg == count_reg - CW'(1));
    assign out_load   = (state_reg == S_OUT || state_reg == S_RES) && (!m_tvalid || m_tready);
    assign s_kind     = kind_t'(s_tdata[1:0]);

    logic wr_en;
    logic [AW-1:0] wr_addr;
    entry_t wr_data;

    always_comb begin
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = pos_reg[AW-1:0];
        wr_data = cur_reg;
        unique case (state_reg)
            S_UP_RD: begin
                if (pos_reg == '0) wr_en = 1'b1;
                else rd_addr = par[AW-1:0];
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (up_move) wr_data = rd_reg;
            end
            S_DN_L: begin
                if (lch < PW'(lim_reg)) rd_addr = lch[AW-1:0];
            end
            S_DN_R: begin
                if (rch < PW'(lim_reg)) rd_addr = rch[AW-1:0];
            end
            S_DN_W: begin
                wr_en = 1'b1;
                if (big_reg != pos_reg) wr_data = big_e_reg;
            end
            S_SORT_SWAP: begin
                // The old slot is read while the root is written over it.
                rd_addr = idx_reg[AW-1:0];
                wr_en = 1'b1;
                wr_addr = idx_reg[AW-1:0];
                wr_data = rd_reg;
            end
            S_OUT_RD, S_OUT, S_CHK_RD: rd_addr = idx_reg[AW-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            m_tvalid <= 1'b0;
        end else begin
            if (out_load) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        cur_reg <= '{id: s_tdata[25:2], distance: s_tdata[57:26]};
                        key_reg <= s_tdata[25:2];
                        idx_reg <= (s_kind == KIND_DRAIN) ? count_reg - CW'(1) : '0;
                        hit_reg <= 1'b0;
                        empty_reg <= (s_kind == KIND_DRAIN) && (count_reg == '0);
                        unique case (s_kind)
                            KIND_OFFER: begin
                                if (count_reg < CW'(HEAP_CAPACITY)) begin
                                    pos_reg <= PW'(count_reg);
                                    count_reg <= count_reg + CW'(1);
                                    state_reg <= S_UP_RD;
                                end else begin
                                    state_reg <= S_ROOT_RD;
                                end
                            end
                            KIND_DRAIN: begin
                                if (count_reg == '0) state_reg <= S_RES;
                                else if (count_reg == CW'(1)) state_reg <= S_OUT_RD;
                                else state_reg <= S_SORT_RD;
                            end
                            KIND_CHECK: state_reg <= (count_reg == '0) ? S_RES : S_CHK_RD;
                            KIND_NONE: ;
                        endcase
                    end
                end
                S_UP_RD: state_reg <= (pos_reg == '0) ? S_IDLE : S_UP_CMP;
                S_UP_CMP: begin
                    if (up_move) begin
                        pos_reg <= par;
                        state_reg <= S_UP_RD;
                    end else state_reg <= S_IDLE;
                end
                S_ROOT_RD: state_reg <= S_ROOT_CMP;
                S_ROOT_CMP: begin
                    // Ties never displace the root.
                    if (cur_reg.distance < rd_reg.distance) begin
                        pos_reg <= '0;
                        lim_reg <= count_reg;
                        state_reg <= S_DN_L;
                    end else state_reg <= S_IDLE;
                end
                S_DN_L: begin
                    if (lch < PW'(lim_reg)) begin
                        state_reg <= S_DN_R;
                    end else begin
                        big_reg <= pos_reg;
                        state_reg <= S_DN_W;
                    end
                end
                S_DN_R: begin
                    if (rd_reg.distance > cur_reg.distance) begin
                        big_reg <= lch;
                        big_e_reg <= rd_reg;
                    end else begin
                        big_reg <= pos_reg;
                        big_e_reg <= cur_reg;
                    end
                    state_reg <= (rch < PW'(lim_reg)) ? S_DN_C : S_DN_W;
                end
                S_DN_C: begin
                    if (right_wins) begin
                        big_reg <= rch;
                        big_e_reg <= rd_reg;
                    end
                    state_reg <= S_DN_W;
                end
                S_DN_W: begin
                    if (big_reg != pos_reg) begin
                        pos_reg <= big_reg;
                        state_reg <= S_DN_L;
                    end else if (idx_reg == '0) begin
                        state_reg <= S_IDLE;
                    end else if (idx_reg == CW'(1)) begin
                        idx_reg <= '0;
                        state_reg <= S_OUT_RD;
                    end else begin
                        idx_reg <= idx_reg - CW'(1);
                        state_reg <= S_SORT_RD;
                    end
                end
                S_SORT_RD: state_reg <= S_SORT_SWAP;
                S_SORT_SWAP: state_reg <= S_SORT_LD;
                S_SORT_LD: begin
                    cur_reg <= rd_reg;
                    pos_reg <= '0;
                    lim_reg <= idx_reg;
                    state_reg <= S_DN_L;
                end
                S_OUT_RD: state_reg <= S_OUT;
                S_OUT: begin
                    if (out_load) begin
                        m_tdata <= {8'd0, rd_reg.distance, rd_reg.id};
                        m_tuser <= 2'b00;
                        m_tlast <= at_last;
                        if (at_last) begin
                            count_reg <= '0;
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_reg + CW'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                S_CHK_RD: state_reg <= S_CHK;
                S_CHK: begin
                    if (rd_reg.id == key_reg) hit_reg <= 1'b1;
                    if (at_last) begin
                        state_reg <= S_RES;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_CHK_RD;
                    end
                end
                S_RES: begin
                    if (out_load) begin
                        m_tdata <= '0;
                        m_tuser <= {empty_reg, hit_reg};
                        m_tlast <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(HEAP_CAPACITY))
        else $error("entry count beyond capacity");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable({m_tdata, m_tuser, m_tlast}))
        else $error("result changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:56] == 8'd0)
        else $error("result padding not zero");
endmodule

// ===== test/tb.sv =====
module tb;
    import ksdh_pkg::*;

    localparam int CAP = 16;

    typedef struct {
        logic [23:0] id;
        logic [31:0] distance;
        logic        found;
        logic        empty_res;
        logic        last;
    } heap_result_t;

    class heap_scoreboard;
        logic [23:0]  ids[CAP];
        logic [31:0]  dists[CAP];
        int           count;
        heap_result_t pending[$];
        int           errors;
        int           checked;

        function new();
            count = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void swap_slots(int a, int b);
            logic [23:0] ti;
            logic [31:0] td;
            ti = ids[a];
            ids[a] = ids[b];
            ids[b] = ti;
            td = dists[a];
            dists[a] = dists[b];
            dists[b] = td;
        endfunction

        function void push_down(int pos, int n);
            int l;
            int r;
            int big;
            while (pos < n) begin
                l = 2 * pos + 1;
                r = 2 * pos + 2;
                big = pos;
                if (l < n && dists[l] > dists[big]) big = l;
                if (r < n && dists[r] > dists[big]) big = r;
                if (big == pos) break;
                swap_slots(pos, big);
                pos = big;
            end
        endfunction

        function void push_up(int pos);
            int parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (!(dists[parent] < dists[pos])) break;
                swap_slots(parent, pos);
                pos = parent;
            end
        endfunction

        function heap_result_t make(logic [23:0] id, logic [31:0] d, logic f, logic e,
                                    logic l);
            heap_result_t r;
            r.id = id;
            r.distance = d;
            r.found = f;
            r.empty_res = e;
            r.last = l;
            return r;
        endfunction

        // Updates the heap copy and queues whatever results the transfer causes.
        function void note_input(kind_t kind, logic [23:0] id, logic [31:0] d);
            bit hit;
            hit = 0;
            case (kind)
                KIND_OFFER: begin
                    if (count >= CAP) begin
                        if (d < dists[0]) begin
                            ids[0] = id;
                            dists[0] = d;
                            push_down(0, count);
                        end
                    end else begin
                        ids[count] = id;
                        dists[count] = d;
                        push_up(count);
                        count++;
                    end
                end
                KIND_DRAIN: begin
                    if (count == 0) begin
                        pending.push_back(make(24'd0, 32'd0, 1'b0, 1'b1, 1'b1));
                    end else begin
                        for (int i = count - 1; i > 0; i--) begin
                            swap_slots(0, i);
                            push_down(0, i);
                        end
                        for (int i = 0; i < count; i++)
                            pending.push_back(make(ids[i], dists[i], 1'b0, 1'b0,
                                                   i == count - 1));
                        count = 0;
                    end
                end
                KIND_CHECK: begin
                    for (int i = 0; i < count; i++)
                        if (ids[i] == id) hit = 1;
                    pending.push_back(make(24'd0, 32'd0, hit, 1'b0, 1'b1));
                end
                default: ;
            endcase
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(logic [63:0] data, logic [1:0] user, logic last);
            heap_result_t e;
            checked++;
            if (pending.size() == 0) begin
                report("unexpected transfer", data[31:0], 32'd0);
                return;
            end
            e = pending.pop_front();
            if (data[23:0] !== e.id) report("out_id", 32'(data[23:0]), 32'(e.id));
            if (data[55:24] !== e.distance) report("out_distance", data[55:24], e.distance);
            if (data[63:56] !== 8'd0) report("tdata padding", 32'(data[63:56]), 32'd0);
            if (user[0] !== e.found) report("found", 32'(user[0]), 32'(e.found));
            if (user[1] !== e.empty_res) report("empty_res", 32'(user[1]), 32'(e.empty_res));
            if (last !== e.last) report("last", 32'(last), 32'(e.last));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    heap_scoreboard sb;
    longint cycle_count;
    bit     stimulus_done;
    int     offers;
    int     drains;
    int     checks;

    k_smallest_distance_heap #(.HEAP_CAPACITY(CAP)) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    function int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One transfer on the input side; a gap drops tvalid before the item is shown.
    task send_item(kind_t kind, logic [23:0] id, logic [31:0] d, bit idle);
        int g;
        g = idle ? gap_length() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            s_tdata <= {$urandom, $urandom};
            repeat (g) @(negedge aclk);
        end
        s_tdata <= {6'd0, d, id, kind};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(kind, id, d);
        case (kind)
            KIND_OFFER: offers++;
            KIND_DRAIN: drains++;
            KIND_CHECK: checks++;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task stop_input();
        s_tvalid <= 1'b0;
    endtask

    task wait_drained();
        stop_input();
        @(negedge aclk);
        while (sb.pending.size() != 0) @(negedge aclk);
    endtask

    function logic [31:0] rand_dist();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        stimulus_done = 0;
        offers = 0;
        drains = 0;
        checks = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: empty drain, check on empty, ties, extremes, overflow.
        send_item(KIND_DRAIN, 24'h0, 32'h0, 1'b0);
        send_item(KIND_CHECK, 24'hFFFFFF, 32'h0, 1'b0);
        send_item(KIND_NONE, 24'h123456, 32'h5, 1'b0);
        send_item(KIND_OFFER, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(KIND_OFFER, 24'h000000, 32'h0000_0000, 1'b0);
        send_item(KIND_OFFER, 24'h000001, 32'h0001_0000, 1'b0);
        send_item(KIND_OFFER, 24'h000002, 32'h0001_0000, 1'b0);
        send_item(KIND_CHECK, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
        send_item(KIND_CHECK, 24'hABCDEF, 32'h0, 1'b0);
        send_item(KIND_DRAIN, 24'h0, 32'h0, 1'b0);
        // Fill past capacity, including ties with the root.
        for (int i = 0; i < CAP + 4; i++)
            send_item(KIND_OFFER, 24'(i + 16), (i < CAP) ? 32'(100 + i % 5) : 32'd104, 1'b0);
        send_item(KIND_OFFER, 24'h555555, 32'd3, 1'b0);
        send_item(KIND_DRAIN, 24'h0, 32'h0, 1'b1);
        wait_drained();

        // Random: mostly fill-and-drain sequences with checks mixed in.
        for (int n = 0; n < 120; ) begin
            int fill;
            fill = ($urandom_range(0, 3) == 0) ? $urandom_range(CAP, CAP + 12)
                                                : $urandom_range(0, CAP);
            for (int i = 0; i < fill; i++) begin
                logic [23:0] id;
                id = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 31)) : 24'($urandom);
                send_item(KIND_OFFER, id, rand_dist(), 1'b1);
                n++;
                if ($urandom_range(0, 5) == 0) begin
                    send_item(KIND_CHECK, 24'($urandom_range(0, 31)), $urandom, 1'b1);
                    n++;
                end
                if ($urandom_range(0, 30) == 0)
                    send_item(KIND_NONE, 24'($urandom), $urandom, 1'b1);
            end
            if (n > 60 && drains % 4 == 2) wait_drained();
            send_item(KIND_DRAIN, 24'($urandom), $urandom, 1'b1);
            n++;
        end
        send_item(KIND_DRAIN, 24'h0, 32'h0, 1'b1);
        stop_input();
        stimulus_done = 1;
    end

    initial begin
        int g;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                g = gap_length();
                if (g > 0) begin
                    m_tready <= 1'b0;
                    repeat (g) @(negedge aclk);
                end
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 400000) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Covered %0d offers, %0d drains and %0d checks; %0d result transfers checked.",
                 offers, drains, checks, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
